FILE: rtl/core/vfc_pkg.sv
// shared types, constants and codes of the voxel face culling block
package vfc_pkg;

	localparam int CHUNK_SIDE_DEF   = 16;
	localparam int CHUNK_HEIGHT_DEF = 64;

	localparam int XY_W   = 4;
	localparam int Z_W    = 6;
	localparam int MASK_W = 6;
	localparam int CNT_W  = 3;
	localparam int VCNT_W = 19;

	localparam logic [VCNT_W-1:0] VCNT_MAX = {VCNT_W{1'b1}};
	// four vertices per face, as a shift of the face count
	localparam int VERTS_SHIFT = 2;

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// face bit positions
	localparam int FACE_PX = 0;
	localparam int FACE_PY = 1;
	localparam int FACE_NX = 2;
	localparam int FACE_NY = 3;
	localparam int FACE_PZ = 4;
	localparam int FACE_NZ = 5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_C,
		ST_WR,
		ST_RD_PY,
		ST_RD_NY,
		ST_RD_PZ,
		ST_RD_NZ,
		ST_RD_LAST,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		SEL_CENTER,
		SEL_PY,
		SEL_NY,
		SEL_PZ,
		SEL_NZ,
		SEL_CLR
	} addr_sel_t;

	typedef struct packed {
		addr_sel_t sel;
		logic      ram_we;
		logic      wr_clear;
		logic      clr_inc;
		logic      take_in;
		logic      cap_c;
		logic      cap_py;
		logic      cap_ny;
		logic      cap_pz;
		logic      cap_nz;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_write;
		logic in_chunk;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/core/voxel_face_culling.sv
// top level of the voxel face culling block
//
// input channel (in_valid / in_stall): one item per transfer; opcode 0 writes
// solid_bit at (x_coord, y_coord, z_coord), opcode 1 queries that voxel's faces.
// output channel (out_valid / out_stall): exactly one result per input item,
// in order: face_mask (+X,+Y,-X,-Y,+Z,-Z), face_count and first_vertex.
// writes return an all-zero result; queries on air or outside the chunk give
// a zero mask with the current vertex counter.
// the solid map lives in one single-port ram, one x row per word, so a query
// reads five rows (center row gives +X/-X too) one per cycle through that port.
// a query steps through states RD_C, RD_PY, RD_NY, RD_PZ, RD_NZ, RD_LAST, FIN and a
// write through RD_C, WR, FIN; one item is worked on at a time, the next is taken only
// after the last one's result is loaded, so the serial row reads set the pace.
// after reset the block runs a clearing pass over all CHUNK_SIDE*CHUNK_HEIGHT rows
// (1024 at default size) that zeroes the map, holding in_stall high meanwhile.
// a stalled result stays in the output register; the next item is still taken
// and worked on, and waits only at hand-off until the output register frees up.
module voxel_face_culling #(
	parameter int CHUNK_SIDE   = vfc_pkg::CHUNK_SIDE_DEF,
	parameter int CHUNK_HEIGHT = vfc_pkg::CHUNK_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [vfc_pkg::XY_W-1:0]   x_coord,
	input  logic [vfc_pkg::XY_W-1:0]   y_coord,
	input  logic [vfc_pkg::Z_W-1:0]    z_coord,
	input  logic                       solid_bit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [vfc_pkg::MASK_W-1:0] face_mask,
	output logic [vfc_pkg::CNT_W-1:0]  face_count,
	output logic [vfc_pkg::VCNT_W-1:0] first_vertex
);
	import vfc_pkg::*;

	// one word per x row of the chunk
	localparam int Depth = CHUNK_SIDE * CHUNK_HEIGHT;
	localparam int RowAw = $clog2(Depth);

	cmd_t cmd;
	sts_t sts;

	logic                  ram_we;
	logic [RowAw-1:0]      ram_addr;
	logic [CHUNK_SIDE-1:0] ram_wdata;
	logic [CHUNK_SIDE-1:0] ram_rdata;

	// sequencing of clear pass, row reads and result hand-off
	vfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// addressing, face tests, counter and output register
	vfc_dp #(
		.CHUNK_SIDE   (CHUNK_SIDE),
		.CHUNK_HEIGHT (CHUNK_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.z_coord      (z_coord),
		.solid_bit    (solid_bit),
		.ram_we       (ram_we),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.face_mask    (face_mask),
		.face_count   (face_count),
		.first_vertex (first_vertex)
	);

	// solid map storage
	vfc_ram #(
		.WIDTH (CHUNK_SIDE),
		.DEPTH (Depth)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// the face count always matches the mask it goes with
	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(face_count) == $countones(face_mask)))
		else $error("face_count does not match face_mask");

	// an accepted item keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transfer");

	// a new result is only loaded when the output register is free
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled result");

	// the map is written only by the clearing pass or a voxel write
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cmd.wr_clear || sts.is_write))
		else $error("map written during a query");
`endif

endmodule

FILE: rtl/core/vfc_ram.sv
// generic single-port ram with registered read data
module vfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/vfc_ctrl.sv
// controller state machine: clearing pass, item sequencing, result hand-off
module vfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vfc_pkg::sts_t sts,
	output vfc_pkg::cmd_t cmd
);
	import vfc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE:    if (in_valid) state_d = ST_RD_C;
			ST_RD_C:    state_d = sts.is_write ? ST_WR : ST_RD_PY;
			ST_WR:      state_d = ST_FIN;
			ST_RD_PY:   state_d = ST_RD_NY;
			ST_RD_NY:   state_d = ST_RD_PZ;
			ST_RD_PZ:   state_d = ST_RD_NZ;
			ST_RD_NZ:   state_d = ST_RD_LAST;
			ST_RD_LAST: state_d = ST_FIN;
			ST_FIN:     if (sts.out_free) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_CENTER;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.sel      = SEL_CLR;
				cmd.ram_we   = 1'b1;
				cmd.wr_clear = 1'b1;
				cmd.clr_inc  = 1'b1;
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.take_in = in_valid;
			end
			ST_RD_C: begin
				cmd.sel = SEL_CENTER;
			end
			ST_WR: begin
				cmd.sel    = SEL_CENTER;
				cmd.ram_we = sts.in_chunk;
			end
			ST_RD_PY: begin
				cmd.sel   = SEL_PY;
				cmd.cap_c = 1'b1;
			end
			ST_RD_NY: begin
				cmd.sel    = SEL_NY;
				cmd.cap_py = 1'b1;
			end
			ST_RD_PZ: begin
				cmd.sel    = SEL_PZ;
				cmd.cap_ny = 1'b1;
			end
			ST_RD_NZ: begin
				cmd.sel    = SEL_NZ;
				cmd.cap_pz = 1'b1;
			end
			ST_RD_LAST: begin
				cmd.cap_nz = 1'b1;
			end
			ST_FIN: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd.sel = SEL_CENTER;
			end
		endcase
	end

endmodule

FILE: rtl/core/vfc_dp.sv
// datapath: item registers, row addressing, face mask, vertex counter, result register
module vfc_dp #(
	parameter int CHUNK_SIDE   = vfc_pkg::CHUNK_SIDE_DEF,
	parameter int CHUNK_HEIGHT = vfc_pkg::CHUNK_HEIGHT_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  vfc_pkg::cmd_t                                cmd,
	output vfc_pkg::sts_t                                sts,
	input  logic                                         opcode,
	input  logic [vfc_pkg::XY_W-1:0]                     x_coord,
	input  logic [vfc_pkg::XY_W-1:0]                     y_coord,
	input  logic [vfc_pkg::Z_W-1:0]                      z_coord,
	input  logic                                         solid_bit,
	output logic                                         ram_we,
	output logic [$clog2(CHUNK_SIDE*CHUNK_HEIGHT)-1:0]   ram_addr,
	output logic [CHUNK_SIDE-1:0]                        ram_wdata,
	input  logic [CHUNK_SIDE-1:0]                        ram_rdata,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic [vfc_pkg::MASK_W-1:0]                   face_mask,
	output logic [vfc_pkg::CNT_W-1:0]                    face_count,
	output logic [vfc_pkg::VCNT_W-1:0]                   first_vertex
);
	import vfc_pkg::*;

	localparam int Depth  = CHUNK_SIDE * CHUNK_HEIGHT;
	localparam int RowAw  = $clog2(Depth);
	localparam int XiW    = (CHUNK_SIDE > 1) ? $clog2(CHUNK_SIDE) : 1;

	// item registers
	logic              op_q;
	logic              sb_q;
	logic              in_chunk_q;
	logic [MASK_W-1:0] ok_q;
	logic [XiW-1:0]    xi_q;
	logic [XiW-1:0]    xpi_q;
	logic [XiW-1:0]    xni_q;
	logic [RowAw-1:0]  base_q;

	logic [RowAw-1:0]  clr_q;
	logic              solid_q;
	logic [MASK_W-1:0] mask_q;
	logic [VCNT_W-1:0] vcnt_q;

	logic              out_valid_q;
	logic [MASK_W-1:0] mask_out_q;
	logic [CNT_W-1:0]  count_out_q;
	logic [VCNT_W-1:0] first_out_q;

	logic              in_chunk_d;
	logic [MASK_W-1:0] ok_d;
	logic [RowAw-1:0]  base_d;
	logic [CHUNK_SIDE-1:0] bit_sel;
	logic [MASK_W-1:0] mask_eff;
	logic [CNT_W-1:0]  count_eff;
	logic [VCNT_W-1:0] add_ext;
	logic [VCNT_W-1:0] vcnt_next;

	// chunk bounds of the incoming voxel and of its neighbours
	always_comb begin
		in_chunk_d = (32'(x_coord) < 32'(CHUNK_SIDE)) &&
			(32'(y_coord) < 32'(CHUNK_SIDE)) &&
			(32'(z_coord) < 32'(CHUNK_HEIGHT));
		ok_d          = '0;
		ok_d[FACE_PX] = in_chunk_d && (32'(x_coord) + 32'd1 < 32'(CHUNK_SIDE));
		ok_d[FACE_NX] = in_chunk_d && (x_coord != '0);
		ok_d[FACE_PY] = in_chunk_d && (32'(y_coord) + 32'd1 < 32'(CHUNK_SIDE));
		ok_d[FACE_NY] = in_chunk_d && (y_coord != '0);
		ok_d[FACE_PZ] = in_chunk_d && (32'(z_coord) + 32'd1 < 32'(CHUNK_HEIGHT));
		ok_d[FACE_NZ] = in_chunk_d && (z_coord != '0);
		base_d = in_chunk_d ?
			RowAw'(32'(z_coord) * 32'(CHUNK_SIDE) + 32'(y_coord)) : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q       <= opcode;
			sb_q       <= solid_bit;
			in_chunk_q <= in_chunk_d;
			ok_q       <= ok_d;
			xi_q       <= XiW'(x_coord);
			xpi_q      <= XiW'(32'(x_coord) + 32'd1);
			xni_q      <= XiW'(32'(x_coord) - 32'd1);
			base_q     <= base_d;
		end
	end

	// row address select; neighbours outside the chunk fall back to the center row
	always_comb begin
		case (cmd.sel)
			SEL_CENTER: ram_addr = base_q;
			SEL_PY:     ram_addr = ok_q[FACE_PY] ? base_q + RowAw'(1) : base_q;
			SEL_NY:     ram_addr = ok_q[FACE_NY] ? base_q - RowAw'(1) : base_q;
			SEL_PZ:     ram_addr = ok_q[FACE_PZ] ? base_q + RowAw'(CHUNK_SIDE) : base_q;
			SEL_NZ:     ram_addr = ok_q[FACE_NZ] ? base_q - RowAw'(CHUNK_SIDE) : base_q;
			SEL_CLR:    ram_addr = clr_q;
			default:    ram_addr = base_q;
		endcase
	end

	// read-modify-write of one row for a voxel write
	assign bit_sel   = CHUNK_SIDE'(1) << xi_q;
	assign ram_we    = cmd.ram_we;
	assign ram_wdata = cmd.wr_clear ? '0 :
		((ram_rdata & ~bit_sel) | (sb_q ? bit_sel : '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_inc) begin
			clr_q <= clr_q + RowAw'(1);
		end
	end

	// face capture as row data comes back
	always_ff @(posedge clk) begin
		if (cmd.cap_c) begin
			solid_q         <= in_chunk_q && ram_rdata[xi_q];
			mask_q[FACE_PX] <= !(ok_q[FACE_PX] && ram_rdata[xpi_q]);
			mask_q[FACE_NX] <= !(ok_q[FACE_NX] && ram_rdata[xni_q]);
		end
		if (cmd.cap_py) begin
			mask_q[FACE_PY] <= !(ok_q[FACE_PY] && ram_rdata[xi_q]);
		end
		if (cmd.cap_ny) begin
			mask_q[FACE_NY] <= !(ok_q[FACE_NY] && ram_rdata[xi_q]);
		end
		if (cmd.cap_pz) begin
			mask_q[FACE_PZ] <= !(ok_q[FACE_PZ] && ram_rdata[xi_q]);
		end
		if (cmd.cap_nz) begin
			mask_q[FACE_NZ] <= !(ok_q[FACE_NZ] && ram_rdata[xi_q]);
		end
	end

	// result and saturating vertex counter
	always_comb begin
		mask_eff  = (op_q == OP_QUERY && solid_q) ? mask_q : '0;
		count_eff = '0;
		for (int i = 0; i < MASK_W; i++) begin
			count_eff = count_eff + CNT_W'(mask_eff[i]);
		end
		add_ext   = VCNT_W'({count_eff, {VERTS_SHIFT{1'b0}}});
		vcnt_next = (vcnt_q > VCNT_MAX - add_ext) ? VCNT_MAX : vcnt_q + add_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				vcnt_q      <= vcnt_next;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mask_out_q  <= mask_eff;
			count_out_q <= count_eff;
			first_out_q <= (op_q == OP_QUERY) ? vcnt_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign face_mask    = mask_out_q;
	assign face_count   = count_out_q;
	assign first_vertex = first_out_q;

	always_comb begin
		sts            = '0;
		sts.clear_last = (clr_q == RowAw'(Depth - 1));
		sts.is_write   = (op_q == OP_WRITE);
		sts.in_chunk   = in_chunk_q;
		sts.out_free   = !out_valid_q || !out_stall;
	end

endmodule

FILE: tb/tb_voxel_face_culling.sv
`timescale 1ns / 1ps
// self-checking testbench of the voxel face culling block: solid map writes and face queries
module tb_voxel_face_culling;
	import vfc_pkg::*;

	localparam int SIDE           = CHUNK_SIDE_DEF;
	localparam int HEIGHT         = CHUNK_HEIGHT_DEF;
	localparam int VOXELS         = SIDE * SIDE * HEIGHT;
	localparam int VERTS_PER_FACE = 4;
	// edge length of the small box that random bursts work in, so that neighbors collide
	localparam int BOX            = 4;
	localparam int BURST          = 40;
	localparam int RANDOM_OPS     = 560;
	// repeated six-face queries on one isolated voxel
	localparam int ISOLATED_QUERIES = 40;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 1500000;

	typedef struct packed {
		logic             op;
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic [Z_W-1:0]   z;
		logic             solid;
	} voxel_op_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [CNT_W-1:0]  count;
		logic [VCNT_W-1:0] first;
	} face_result_t;

	// every block input starts at a known value
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              opcode    = OP_WRITE;
	logic [XY_W-1:0]   x_coord   = '0;
	logic [XY_W-1:0]   y_coord   = '0;
	logic [Z_W-1:0]    z_coord   = '0;
	logic              solid_bit = 1'b0;
	logic              out_stall = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic [MASK_W-1:0] face_mask;
	logic [CNT_W-1:0]  face_count;
	logic [VCNT_W-1:0] first_vertex;

	// predictor state: one solid bit per voxel and the running vertex total
	bit                solid_voxels [VOXELS];
	logic [VCNT_W-1:0] vertex_total = '0;

	voxel_op_t    pending_ops[$];
	face_result_t expected_faces[$];
	voxel_op_t    drive_op;
	bit           op_taken;
	int           ops_queued    = 0;
	int           ops_accepted  = 0;
	int           mismatches    = 0;
	int           cycle_count   = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	voxel_face_culling uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.z_coord      (z_coord),
		.solid_bit    (solid_bit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.face_mask    (face_mask),
		.face_count   (face_count),
		.first_vertex (first_vertex)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// anything past the chunk border counts as air
	function automatic bit solid_at(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= HEIGHT)
			return 1'b0;
		return solid_voxels[(z * SIDE + y) * SIDE + x];
	endfunction

	// applies one transfer to the predictor state and returns the result it should produce
	function automatic face_result_t cull_voxel(voxel_op_t v);
		face_result_t r;
		int x, y, z, add;
		r = '0;
		x = int'(v.x);
		y = int'(v.y);
		z = int'(v.z);
		// a write updates the map and returns an all-zero result
		if (v.op == OP_WRITE) begin
			if (x < SIDE && y < SIDE && z < HEIGHT)
				solid_voxels[(z * SIDE + y) * SIDE + x] = v.solid;
			return r;
		end
		// a query reports the counter before its own faces, even on air
		r.first = vertex_total;
		if (solid_at(x, y, z)) begin
			r.mask[FACE_PX] = !solid_at(x + 1, y, z);
			r.mask[FACE_PY] = !solid_at(x, y + 1, z);
			r.mask[FACE_NX] = !solid_at(x - 1, y, z);
			r.mask[FACE_NY] = !solid_at(x, y - 1, z);
			r.mask[FACE_PZ] = !solid_at(x, y, z + 1);
			r.mask[FACE_NZ] = !solid_at(x, y, z - 1);
			r.count = CNT_W'($countones(r.mask));
			add = int'(r.count) * VERTS_PER_FACE;
			// counter sticks at all ones instead of wrapping
			if (int'(vertex_total) > int'(VCNT_MAX) - add)
				vertex_total = VCNT_MAX;
			else
				vertex_total = VCNT_W'(int'(vertex_total) + add);
		end
		return r;
	endfunction

	function automatic void push_op(logic op, int x, int y, int z, logic sb);
		voxel_op_t v;
		v.op    = op;
		v.x     = XY_W'(x);
		v.y     = XY_W'(y);
		v.z     = Z_W'(z);
		v.solid = sb;
		pending_ops.push_back(v);
		ops_queued++;
	endfunction

	// bursts of writes and queries packed into a small box so that faces get hidden,
	// mixed with scattered operations anywhere in the chunk
	task automatic queue_random_ops(int n);
		int ox, oy, oz, write_pct;
		for (int i = 0; i < n; i++) begin
			if (i % BURST == 0) begin
				ox = $urandom_range(SIDE - BOX);
				oy = $urandom_range(SIDE - BOX);
				oz = $urandom_range(HEIGHT - BOX);
			end
			// early in a burst mostly build up the box, later mostly query it
			write_pct = (i % BURST < BURST / 2) ? 70 : 30;
			if ($urandom_range(99) < 80)
				push_op(($urandom_range(99) < write_pct) ? OP_WRITE : OP_QUERY,
					ox + $urandom_range(BOX - 1), oy + $urandom_range(BOX - 1),
					oz + $urandom_range(BOX - 1), $urandom_range(99) < 75);
			else
				push_op(1'($urandom_range(1)), $urandom_range(SIDE - 1),
					$urandom_range(SIDE - 1), $urandom_range(HEIGHT - 1),
					1'($urandom_range(1)));
		end
	endtask

	// sender holds off until every queued transfer is in and every result is out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (ops_accepted != ops_queued || expected_faces.size() != 0);
		@(posedge clk);
	endtask

	// input side: note the transfer at the rising edge and feed the predictor
	always @(posedge clk) begin
		op_taken = arst_n && in_valid && !in_stall;
		if (op_taken) begin
			expected_faces.push_back(cull_voxel(drive_op));
			ops_accepted++;
		end
	end

	// input side: present a new item at the falling edge once the old one is gone;
	// a stalled item stays put, idling is a coin toss independent of stall
	always @(negedge clk) begin
		if (arst_n && (!in_valid || op_taken)) begin
			if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_op = pending_ops.pop_front();
				in_valid  <= 1'b1;
				opcode    <= drive_op.op;
				x_coord   <= drive_op.x;
				y_coord   <= drive_op.y;
				z_coord   <= drive_op.z;
				solid_bit <= drive_op.solid;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		face_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_faces.size() == 0) begin
				$display("%0t: unexpected result mask %b count %0d first %0d", $time,
					face_mask, face_count, first_vertex);
				mismatches++;
			end else begin
				want = expected_faces.pop_front();
				if (face_mask !== want.mask) begin
					$display("%0t: face_mask expected %b got %b", $time, want.mask, face_mask);
					mismatches++;
				end
				if (face_count !== want.count) begin
					$display("%0t: face_count expected %0d got %0d", $time, want.count,
						face_count);
					mismatches++;
				end
				if (first_vertex !== want.first) begin
					$display("%0t: first_vertex expected %0d got %0d", $time, want.first,
						first_vertex);
					mismatches++;
				end
			end
		end
	end

	// output side: random back-pressure
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog, sized well past the slowest legal run including the clearing pass
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		#1 arst_n = 1'b1;

		// sender idles lightly, receiver heavily
		send_idle_pct = 14;
		recv_idle_pct = 45;

		// lone voxels in opposite corners: every face visible, border counts as air
		push_op(OP_WRITE, 0, 0, 0, 1'b1);
		push_op(OP_WRITE, SIDE - 1, SIDE - 1, HEIGHT - 1, 1'b1);
		push_op(OP_QUERY, 0, 0, 0, 1'b0);
		push_op(OP_QUERY, SIDE - 1, SIDE - 1, HEIGHT - 1, 1'b0);
		// query on air, with solid_bit set to show it is ignored
		push_op(OP_QUERY, 1, 1, 1, 1'b1);
		// a solid neighbor hides the +X face
		push_op(OP_WRITE, 1, 0, 0, 1'b1);
		push_op(OP_QUERY, 0, 0, 0, 1'b0);
		// fully enclosed voxel: solid but no visible face
		push_op(OP_WRITE, 5, 5, 5, 1'b1);
		push_op(OP_WRITE, 6, 5, 5, 1'b1);
		push_op(OP_WRITE, 5, 6, 5, 1'b1);
		push_op(OP_WRITE, 4, 5, 5, 1'b1);
		push_op(OP_WRITE, 5, 4, 5, 1'b1);
		push_op(OP_WRITE, 5, 5, 6, 1'b1);
		push_op(OP_WRITE, 5, 5, 4, 1'b1);
		push_op(OP_QUERY, 5, 5, 5, 1'b0);
		// open the top again, only +Z shows
		push_op(OP_WRITE, 5, 5, 6, 1'b0);
		push_op(OP_QUERY, 5, 5, 5, 1'b0);
		// clearing a voxel back to air
		push_op(OP_WRITE, 0, 0, 0, 1'b0);
		push_op(OP_QUERY, 0, 0, 0, 1'b1);
		push_op(OP_QUERY, 1, 0, 0, 1'b0);
		queue_random_ops(RANDOM_OPS);
		wait_drained();

		// roles swapped: bursty sender, mostly ready receiver
		send_idle_pct = 45;
		recv_idle_pct = 14;
		queue_random_ops(RANDOM_OPS);
		wait_drained();

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_ops(RANDOM_OPS);
		// isolate one voxel and query it over and over, all six faces each time
		push_op(OP_WRITE, 9, 8, 32, 1'b0);
		push_op(OP_WRITE, 8, 9, 32, 1'b0);
		push_op(OP_WRITE, 7, 8, 32, 1'b0);
		push_op(OP_WRITE, 8, 7, 32, 1'b0);
		push_op(OP_WRITE, 8, 8, 33, 1'b0);
		push_op(OP_WRITE, 8, 8, 31, 1'b0);
		push_op(OP_WRITE, 8, 8, 32, 1'b1);
		for (int i = 0; i < ISOLATED_QUERIES; i++)
			push_op(OP_QUERY, 8, 8, 32, 1'b0);
		// a write in between still returns zero, then the hidden +X face drops out
		push_op(OP_WRITE, 9, 8, 32, 1'b1);
		push_op(OP_QUERY, 8, 8, 32, 1'b0);
		push_op(OP_QUERY, 3, 3, 3, 1'b0);
		wait_drained();

		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/vfc_pkg.sv
rtl/core/vfc_ram.sv
rtl/core/vfc_ctrl.sv
rtl/core/vfc_dp.sv
rtl/core/voxel_face_culling.sv
tb/tb_voxel_face_culling.sv
